FILE: design/dwh_pkg.sv
package dwh_pkg;

	localparam int CHANNELS = 16;
	localparam logic [15:0] MARKER_WORD = 16'h8b0a;
	localparam logic [15:0] EMPTY_WORD = 16'h0000;
	localparam logic [4:0] MARKER_MODULE = 5'd8;
	localparam logic [4:0] MODULE_SAT = 5'd31;
	localparam logic [14:0] COUNT_MAX = 15'd32767;

	localparam logic [1:0] ACT_PARSE = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] REG_HIST_MIN = 2'd0;
	localparam logic [1:0] REG_HIST_MAX = 2'd1;
	localparam logic [1:0] REG_BIN_SHIFT = 2'd2;

	localparam logic [2:0] STS_HEADER = 3'd0;
	localparam logic [2:0] STS_FILLED = 3'd1;
	localparam logic [2:0] STS_DROPPED = 3'd2;
	localparam logic [2:0] STS_MARKER = 3'd3;
	localparam logic [2:0] STS_READ = 3'd4;
	localparam logic [2:0] STS_CLEARED = 3'd5;

	localparam logic [11:0] HIST_MIN_RST = 12'd0;
	localparam logic [12:0] HIST_MAX_RST = 13'd4000;
	localparam logic [3:0] BIN_SHIFT_RST = 4'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BUMP,
		OP_READ,
		OP_CLEAR
	} op_kind_t;

	// one decoded word: which count to touch and the result fields
	typedef struct packed {
		logic has_result;
		op_kind_t kind;
		logic to_edge;
		logic edge_hi;
		logic [7:0] hist;
		logic [11:0] idx;
		logic [2:0] status;
		logic [4:0] module_now;
		logic [3:0] flag;
		logic [11:0] sample;
	} dwh_op_t;

endpackage

FILE: design/detector_word_histogrammer_core.sv
// Detector word histogrammer: parses event words and keeps one pulse-height
// histogram per module and channel flag, plus underflow/overflow counts.
// Input channel in_valid/in_ready carries one word: action, first_word, word
// and the sel_* fields used by count read and clear actions.
// Output channel out_valid/out_ready returns one result per word: status,
// count, module_now, channel_flag, sample. Action 3 returns nothing.
// Accept issues the count memory read; the modify state then writes back the
// count and loads the output register once that register is free to take it.
// The single read-then-write of the count memory lets a new word in only after
// the last write-back. The result is visible the cycle after that write-back.
// A new word may be accepted while a result waits in the output register;
// if the receiver stalls, the following word holds in the modify cycle and
// nothing is lost.
// After reset a clearing pass zeroes the count memories, one entry a cycle, over
// all NUM_MODULES*16*NUM_BINS entries (262144 at the defaults); in_ready is low
// meanwhile. Configuration writes on cfg_we/cfg_idx/cfg_data are taken always.
module detector_word_histogrammer_core #(
	parameter int NUM_BINS = 1024,
	parameter int NUM_MODULES = 16,
	localparam int SEL_BIN_W = $clog2(NUM_BINS + 2)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [12:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] action,
	input logic first_word,
	input logic [15:0] word,
	input logic [3:0] sel_module,
	input logic [3:0] sel_channel,
	input logic [SEL_BIN_W-1:0] sel_bin,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [14:0] count,
	output logic [4:0] module_now,
	output logic [3:0] channel_flag,
	output logic [11:0] sample
);
	import dwh_pkg::*;

	localparam int BIN_DEPTH = NUM_MODULES * CHANNELS * NUM_BINS;
	localparam int EDGE_DEPTH = NUM_MODULES * CHANNELS * 2;
	localparam int BIN_AW = $clog2(BIN_DEPTH);
	localparam int EDGE_AW = $clog2(EDGE_DEPTH);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD
	} state_t;

	state_t state_q;
	logic [BIN_AW-1:0] clr_q;
	dwh_op_t op, op_s1;
	logic accept;
	logic advance;

	logic [BIN_AW-1:0] bin_raddr, bin_addr_s1, bin_waddr;
	logic [EDGE_AW-1:0] edge_raddr, edge_addr_s1, edge_waddr;
	logic bin_we, edge_we, bin_re, edge_re;
	logic [14:0] bin_rdata, edge_rdata, wr_val, old_cnt, new_cnt;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign advance = (state_q == ST_MOD) && (!out_valid || out_ready);

	dwh_parser #(
		.NUM_BINS(NUM_BINS),
		.NUM_MODULES(NUM_MODULES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.accept(accept),
		.action(action),
		.first_word(first_word),
		.word(word),
		.sel_module(sel_module),
		.sel_channel(sel_channel),
		.sel_bin(sel_bin),
		.op(op)
	);

	assign bin_raddr = BIN_AW'(op.hist) * BIN_AW'(NUM_BINS) + BIN_AW'(op.idx);
	assign edge_raddr = EDGE_AW'({op.hist, op.edge_hi});
	assign bin_re = accept && (op.kind == OP_BUMP || op.kind == OP_READ) && !op.to_edge;
	assign edge_re = accept && (op.kind == OP_BUMP || op.kind == OP_READ) && op.to_edge;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			bin_addr_s1 <= bin_raddr;
			edge_addr_s1 <= edge_raddr;
		end
	end

	// modify: saturating bump, plain read or clear
	always_comb begin
		old_cnt = op_s1.to_edge ? edge_rdata : bin_rdata;
		case (op_s1.kind)
			OP_BUMP: new_cnt = (old_cnt < COUNT_MAX) ? old_cnt + 15'd1 : old_cnt;
			OP_READ: new_cnt = old_cnt;
			default: new_cnt = 15'd0;
		endcase
	end

	always_comb begin
		bin_we = 1'b0;
		edge_we = 1'b0;
		bin_waddr = bin_addr_s1;
		edge_waddr = edge_addr_s1;
		wr_val = new_cnt;
		if (state_q == ST_CLEAR) begin
			bin_we = 1'b1;
			bin_waddr = clr_q;
			edge_we = ({1'b0, clr_q} < (BIN_AW + 1)'(EDGE_DEPTH));
			edge_waddr = clr_q[EDGE_AW-1:0];
			wr_val = 15'd0;
		end else if (advance && (op_s1.kind == OP_BUMP || op_s1.kind == OP_CLEAR)) begin
			bin_we = !op_s1.to_edge;
			edge_we = op_s1.to_edge;
		end
	end

	dwh_ram #(
		.WIDTH(15),
		.DEPTH(BIN_DEPTH)
	) u_bin_ram (
		.clk(clk),
		.we(bin_we),
		.waddr(bin_waddr),
		.wdata(wr_val),
		.re(bin_re),
		.raddr(bin_raddr),
		.rdata(bin_rdata)
	);

	dwh_ram #(
		.WIDTH(15),
		.DEPTH(EDGE_DEPTH)
	) u_edge_ram (
		.clk(clk),
		.we(edge_we),
		.waddr(edge_waddr),
		.wdata(wr_val),
		.re(edge_re),
		.raddr(edge_raddr),
		.rdata(edge_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_AW'(BIN_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && op.has_result) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status <= op_s1.status;
			count <= (op_s1.kind == OP_CLEAR) ? 15'd0 : new_cnt;
			module_now <= op_s1.module_now;
			channel_flag <= op_s1.flag;
			sample <= op_s1.sample;
		end
	end

endmodule

FILE: design/dwh_ram.sv
module dwh_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/dwh_parser.sv
module dwh_parser #(
	parameter int NUM_BINS = 1024,
	parameter int NUM_MODULES = 16,
	localparam int SEL_BIN_W = $clog2(NUM_BINS + 2)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [12:0] cfg_data,
	input logic accept,
	input logic [1:0] action,
	input logic first_word,
	input logic [15:0] word,
	input logic [3:0] sel_module,
	input logic [3:0] sel_channel,
	input logic [SEL_BIN_W-1:0] sel_bin,
	output dwh_pkg::dwh_op_t op
);
	import dwh_pkg::*;

	logic [11:0] hist_min_q;
	logic [12:0] hist_max_q;
	logic [3:0] bin_shift_q;

	logic [4:0] module_q;
	logic in_channel_q;
	logic [4:0] words_left_q;

	logic [4:0] mod_cur, mod_nxt;
	logic inch_cur, inch_nxt;
	logic [4:0] wl_cur, wl_nxt;
	logic [11:0] smp;
	logic [11:0] diff;
	logic [11:0] idx;
	logic [4:0] mod_inc;

	assign smp = word[11:0];
	assign diff = smp - hist_min_q;
	assign idx = diff >> bin_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_min_q <= HIST_MIN_RST;
			hist_max_q <= HIST_MAX_RST;
			bin_shift_q <= BIN_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HIST_MIN: hist_min_q <= cfg_data[11:0];
				REG_HIST_MAX: hist_max_q <= cfg_data;
				REG_BIN_SHIFT: bin_shift_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mod_cur = first_word ? 5'd0 : module_q;
		inch_cur = first_word ? 1'b0 : in_channel_q;
		wl_cur = first_word ? 5'd0 : words_left_q;
		mod_inc = (mod_cur == MODULE_SAT) ? mod_cur : mod_cur + 5'd1;
		mod_nxt = mod_cur;
		inch_nxt = inch_cur;
		wl_nxt = wl_cur;

		op = '0;
		op.kind = OP_NONE;
		op.module_now = module_q;

		case (action)
			ACT_PARSE: begin
				op.has_result = 1'b1;
				if (word == MARKER_WORD && mod_cur == MARKER_MODULE) begin
					inch_nxt = 1'b0;
					op.status = STS_MARKER;
				end else if (!inch_cur && word == EMPTY_WORD) begin
					mod_nxt = mod_inc;
					op.status = STS_MARKER;
				end else if (!inch_cur) begin
					wl_nxt = 5'($countones(word));
					inch_nxt = 1'b1;
					op.status = STS_HEADER;
				end else begin
					op.flag = word[15:12];
					op.sample = smp;
					if ({1'b0, mod_cur} >= 6'(NUM_MODULES)) begin
						op.status = STS_DROPPED;
					end else begin
						op.status = STS_FILLED;
						op.kind = OP_BUMP;
						op.hist = {mod_cur[3:0], word[15:12]};
						if (smp < hist_min_q) begin
							op.to_edge = 1'b1;
						end else if ({1'b0, smp} >= hist_max_q) begin
							op.to_edge = 1'b1;
							op.edge_hi = 1'b1;
						end else if ({1'b0, idx} >= 13'(NUM_BINS)) begin
							op.to_edge = 1'b1;
							op.edge_hi = 1'b1;
						end else begin
							op.idx = idx;
						end
						if (wl_cur != 5'd0) begin
							wl_nxt = wl_cur - 5'd1;
						end
					end
					if (wl_nxt == 5'd0) begin
						mod_nxt = mod_inc;
						inch_nxt = 1'b0;
					end
				end
				op.module_now = mod_nxt;
			end
			ACT_READ, ACT_CLEAR: begin
				op.has_result = 1'b1;
				op.status = (action == ACT_READ) ? STS_READ : STS_CLEARED;
				op.hist = {sel_module, sel_channel};
				if ({1'b0, sel_module} < 5'(NUM_MODULES)) begin
					if (14'(sel_bin) < 14'(NUM_BINS)) begin
						op.kind = (action == ACT_READ) ? OP_READ : OP_CLEAR;
						op.idx = 12'(sel_bin);
					end else if (14'(sel_bin) == 14'(NUM_BINS)) begin
						op.kind = (action == ACT_READ) ? OP_READ : OP_CLEAR;
						op.to_edge = 1'b1;
					end else if (14'(sel_bin) == 14'(NUM_BINS + 1)) begin
						op.kind = (action == ACT_READ) ? OP_READ : OP_CLEAR;
						op.to_edge = 1'b1;
						op.edge_hi = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_q <= 5'd0;
			in_channel_q <= 1'b0;
			words_left_q <= 5'd0;
		end else if (accept && action == ACT_PARSE) begin
			module_q <= mod_nxt;
			in_channel_q <= inch_nxt;
			words_left_q <= wl_nxt;
		end
	end

endmodule

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dwh_pkg::*;

	localparam int NUM_BINS = 1024;
	localparam int NUM_MODULES = 16;
	localparam int NUM_HISTS = NUM_MODULES * CHANNELS;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 75;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 6;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [10:0] BIN_UNDER = 11'd1024;
	localparam logic [10:0] BIN_OVER = 11'd1025;

	typedef struct packed {
		logic [1:0] action;
		logic first_word;
		logic [15:0] word;
		logic [3:0] sel_module;
		logic [3:0] sel_channel;
		logic [10:0] sel_bin;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [14:0] count;
		logic [4:0] module_now;
		logic [3:0] flag;
		logic [11:0] sample;
	} result_t;

	typedef struct {
		in_word_t stim;
		bit typed;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = REG_HIST_MIN;
	logic [12:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = ACT_PARSE;
	logic first_word = 1'b0;
	logic [15:0] word = '0;
	logic [3:0] sel_module = '0;
	logic [3:0] sel_channel = '0;
	logic [10:0] sel_bin = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [14:0] count;
	logic [4:0] module_now;
	logic [3:0] channel_flag;
	logic [11:0] sample;

	// tags that travel with the offered word for the directed rows
	bit row_typed = 1'b0;
	result_t row_want = '0;

	// predictor copy of the registers and of the block state
	logic [11:0] model_min = HIST_MIN_RST;
	logic [12:0] model_max = HIST_MAX_RST;
	logic [3:0] model_shift = BIN_SHIFT_RST;
	logic [4:0] par_module = '0;
	bit par_open = 1'b0;
	logic [4:0] par_left = '0;
	logic [14:0] hist_bins [0:NUM_HISTS*NUM_BINS-1];
	logic [14:0] hist_edges [0:NUM_HISTS*2-1];

	logic [3:0] last_fill_mod = '0;
	logic [3:0] last_fill_flag = '0;
	logic [10:0] last_fill_bin = '0;

	result_t awaited_results [$];
	dir_row_t dir_rows [$];

	int errors = 0;
	int words_sent = 0;
	int results_checked = 0;
	int fills_seen = 0;
	int drops_seen = 0;
	int selects_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	detector_word_histogrammer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.first_word(first_word),
		.word(word),
		.sel_module(sel_module),
		.sel_channel(sel_channel),
		.sel_bin(sel_bin),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.count(count),
		.module_now(module_now),
		.channel_flag(channel_flag),
		.sample(sample)
	);

	initial begin
		foreach (hist_bins[i]) hist_bins[i] = '0;
		foreach (hist_edges[i]) hist_edges[i] = '0;
	end

	function automatic void next_module();
		if (par_module < MODULE_SAT)
			par_module = par_module + 1'b1;
	endfunction

	// bins the sample into histogram h and returns the updated count
	function automatic logic [14:0] tally_sample(int h, logic [11:0] s);
		int unsigned sv;
		int unsigned idx;
		int unsigned addr;
		sv = s;
		if (sv < model_min)
			idx = NUM_BINS;
		else if (sv >= model_max)
			idx = NUM_BINS + 1;
		else begin
			idx = (sv - model_min) >> model_shift;
			if (idx >= NUM_BINS)
				idx = NUM_BINS + 1;
		end
		last_fill_bin = idx[10:0];
		if (idx < NUM_BINS) begin
			addr = h * NUM_BINS + idx;
			if (hist_bins[addr] < COUNT_MAX)
				hist_bins[addr] = hist_bins[addr] + 1'b1;
			return hist_bins[addr];
		end
		addr = h * 2 + idx - NUM_BINS;
		if (hist_edges[addr] < COUNT_MAX)
			hist_edges[addr] = hist_edges[addr] + 1'b1;
		return hist_edges[addr];
	endfunction

	function automatic void predict_histogram_result(in_word_t it, bit typed, result_t want);
		result_t r;
		int h;
		int unsigned addr;
		r = '0;
		case (it.action)
			ACT_PARSE: begin
				if (it.first_word) begin
					par_module = '0;
					par_open = 1'b0;
					par_left = '0;
				end
				if (it.word == MARKER_WORD && par_module == MARKER_MODULE) begin
					par_open = 1'b0;
					r.status = STS_MARKER;
				end else if (!par_open && it.word == EMPTY_WORD) begin
					next_module();
					r.status = STS_MARKER;
				end else if (!par_open) begin
					par_left = 5'($countones(it.word));
					par_open = 1'b1;
					r.status = STS_HEADER;
				end else begin
					r.flag = it.word[15:12];
					r.sample = it.word[11:0];
					if (par_module >= NUM_MODULES) begin
						r.status = STS_DROPPED;
						drops_seen++;
					end else begin
						h = par_module * CHANNELS + r.flag;
						last_fill_mod = par_module[3:0];
						last_fill_flag = r.flag;
						r.count = tally_sample(h, r.sample);
						if (par_left > 0)
							par_left = par_left - 1'b1;
						r.status = STS_FILLED;
						fills_seen++;
					end
					if (par_left == 0) begin
						next_module();
						par_open = 1'b0;
					end
				end
			end
			ACT_READ, ACT_CLEAR: begin
				h = it.sel_module * CHANNELS + it.sel_channel;
				r.status = (it.action == ACT_READ) ? STS_READ : STS_CLEARED;
				selects_seen++;
				if (it.sel_bin < NUM_BINS) begin
					addr = h * NUM_BINS + it.sel_bin;
					if (it.action == ACT_READ)
						r.count = hist_bins[addr];
					else
						hist_bins[addr] = '0;
				end else if (it.sel_bin <= NUM_BINS + 1) begin
					addr = h * 2 + it.sel_bin - NUM_BINS;
					if (it.action == ACT_READ)
						r.count = hist_edges[addr];
					else
						hist_edges[addr] = '0;
				end
			end
			default: return;
		endcase
		r.module_now = par_module;
		awaited_results.push_back(typed ? want : r);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 200)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (out_valid && out_ready) begin
			got = {status, count, module_now, channel_flag, sample};
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, got status %0d",
					$time, status);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				check_field("status", 16'(want.status), 16'(got.status));
				check_field("count", 16'(want.count), 16'(got.count));
				check_field("module_now", 16'(want.module_now), 16'(got.module_now));
				check_field("channel_flag", 16'(want.flag), 16'(got.flag));
				check_field("sample", 16'(want.sample), 16'(got.sample));
			end
		end
		if (in_valid && in_ready)
			predict_histogram_result({action, first_word, word, sel_module, sel_channel,
				sel_bin}, row_typed, row_want);
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results still awaited", cycles,
			awaited_results.size());
		$display("** detector_word_histogrammer_core: FAILED **");
		$finish;
	end

	task automatic offer_word(in_word_t it, bit typed, result_t want);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		first_word <= it.first_word;
		word <= it.word;
		sel_module <= it.sel_module;
		sel_channel <= it.sel_channel;
		sel_bin <= it.sel_bin;
		row_typed <= typed;
		row_want <= want;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_HIST_MIN: model_min = val[11:0];
			REG_HIST_MAX: model_max = val;
			REG_BIN_SHIFT: model_shift = val[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [11:0] lo, logic [12:0] hi, logic [3:0] sh);
		write_register(REG_HIST_MIN, {1'b0, lo});
		write_register(REG_HIST_MAX, hi);
		write_register(REG_BIN_SHIFT, {9'd0, sh});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_selection();
		in_word_t it;
		it.action = ($urandom_range(9) < 7) ? ACT_READ : ACT_CLEAR;
		it.first_word = 1'($urandom_range(1));
		it.word = 16'($urandom);
		if ($urandom_range(9) < 6) begin
			it.sel_module = last_fill_mod;
			it.sel_channel = last_fill_flag;
			it.sel_bin = last_fill_bin;
		end else begin
			it.sel_module = 4'($urandom);
			it.sel_channel = 4'($urandom);
			case ($urandom_range(3))
				0: it.sel_bin = BIN_UNDER;
				1: it.sel_bin = BIN_OVER;
				default: it.sel_bin = 11'($urandom);
			endcase
		end
		offer_word(it, 1'b0, '0);
	endtask

	// occasional reads, clears, unused actions and stray words between event words
	task automatic maybe_noise();
		in_word_t it;
		int r;
		r = $urandom_range(99);
		if (r < 8) begin
			send_selection();
		end else if (r < 11) begin
			it.action = ACT_UNUSED;
			it.first_word = 1'($urandom_range(1));
			it.word = 16'($urandom);
			it.sel_module = 4'($urandom);
			it.sel_channel = 4'($urandom);
			it.sel_bin = 11'($urandom);
			offer_word(it, 1'b0, '0);
		end else if (r < 14) begin
			it.action = ACT_PARSE;
			it.first_word = ($urandom_range(3) == 0);
			it.word = 16'($urandom);
			it.sel_module = 4'($urandom);
			it.sel_channel = 4'($urandom);
			it.sel_bin = 11'($urandom);
			offer_word(it, 1'b0, '0);
		end
	endtask

	task automatic send_parse(inout bit fw, input logic [15:0] w);
		in_word_t it;
		maybe_noise();
		it.action = ACT_PARSE;
		it.first_word = fw;
		it.word = w;
		it.sel_module = 4'($urandom);
		it.sel_channel = 4'($urandom);
		it.sel_bin = 11'($urandom);
		offer_word(it, 1'b0, '0);
		fw = 1'b0;
	endtask

	function automatic logic [15:0] header_with(int k);
		logic [15:0] hdr;
		hdr = '0;
		while ($countones(hdr) < k)
			hdr[$urandom_range(15)] = 1'b1;
		return hdr;
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 16;
		if (r < 3)
			return $urandom_range(15, 4);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [15:0] data_word();
		logic [3:0] fl;
		logic [11:0] smp;
		fl = 4'($urandom);
		case ($urandom_range(7))
			0: smp = '0;
			1: smp = 12'hfff;
			2: smp = model_min;
			3: smp = 12'(model_max - 13'd1);
			4: smp = model_max[11:0];
			default: smp = 12'($urandom);
		endcase
		return {fl, smp};
	endfunction

	// one event: first word flagged, then empty slots and channels module by module
	task automatic send_event();
		bit fw;
		bit sparse;
		bit all_empty;
		int slots;
		int s;
		int j;
		int k;
		int n;
		logic [4:0] mod_plan;
		fw = 1'b1;
		mod_plan = '0;
		sparse = ($urandom_range(7) == 0);
		all_empty = sparse && $urandom_range(1);
		slots = sparse ? $urandom_range(34, 14) : $urandom_range(6, 1);
		for (s = 0; s < slots; s++) begin
			if (mod_plan == MARKER_MODULE && !fw && $urandom_range(9) < 4)
				send_parse(fw, MARKER_WORD);
			if (all_empty || (sparse ? $urandom_range(9) < 9 : $urandom_range(3) == 0)) begin
				send_parse(fw, EMPTY_WORD);
			end else begin
				k = pick_count();
				send_parse(fw, header_with(k));
				// a channel cut short ends the event early
				n = ($urandom_range(9) == 0) ? $urandom_range(k) : k;
				for (j = 0; j < n; j++) begin
					if (mod_plan == MARKER_MODULE && $urandom_range(9) == 0)
						send_parse(fw, MARKER_WORD);
					send_parse(fw, data_word());
				end
				if (n < k)
					s = slots;
			end
			if (mod_plan < MODULE_SAT)
				mod_plan = mod_plan + 1'b1;
		end
	endtask

	function automatic dir_row_t mk_row(logic [1:0] act, logic fw, logic [15:0] w,
		logic [3:0] sm, logic [3:0] sc, logic [10:0] sb, bit typed, logic [2:0] st,
		logic [14:0] cnt, logic [4:0] mn, logic [3:0] fl, logic [11:0] smp);
		dir_row_t row;
		row.stim = {act, fw, w, sm, sc, sb};
		row.typed = typed;
		row.want = {st, cnt, mn, fl, smp};
		return row;
	endfunction

	initial begin
		int p;
		int phase_start;
		bit hold_asked;
		bit paused;
		hold_asked = 1'b0;
		paused = 1'b0;

		// counts right after the clearing pass, bad selections
		dir_rows.push_back(mk_row(ACT_READ, 0, 16'h0, 0, 0, 0, 1, STS_READ, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_READ, 1, 16'hffff, 15, 15, BIN_OVER, 1,
			STS_READ, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_READ, 0, 16'h0, 3, 7, 11'h7ff, 1, STS_READ, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_CLEAR, 0, 16'h0, 15, 0, 11'd1500, 1,
			STS_CLEARED, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_UNUSED, 1, 16'hffff, 15, 15, 11'h7ff, 0, 0, 0, 0, 0, 0));
		// empty slot, a two-word channel, fill of first bin and overflow
		dir_rows.push_back(mk_row(ACT_PARSE, 1, EMPTY_WORD, 0, 0, 0, 1, STS_MARKER, 0, 1, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, 16'h8001, 0, 0, 0, 1, STS_HEADER, 0, 1, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, 16'hf000, 0, 0, 0, 1, STS_FILLED, 1, 1, 15, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, 16'h0fff, 0, 0, 0, 1,
			STS_FILLED, 1, 2, 0, 12'hfff));
		dir_rows.push_back(mk_row(ACT_READ, 0, 16'h0, 1, 0, BIN_OVER, 1, STS_READ, 1, 2, 0, 0));
		dir_rows.push_back(mk_row(ACT_READ, 0, 16'h0, 1, 15, 0, 1, STS_READ, 1, 2, 0, 0));
		dir_rows.push_back(mk_row(ACT_CLEAR, 0, 16'h0, 1, 15, 0, 1, STS_CLEARED, 0, 2, 0, 0));
		dir_rows.push_back(mk_row(ACT_READ, 0, 16'h0, 1, 15, 0, 1, STS_READ, 0, 2, 0, 0));
		// all-ones header, then a zero word inside the channel is data
		dir_rows.push_back(mk_row(ACT_PARSE, 1, 16'hffff, 0, 0, 0, 1, STS_HEADER, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, EMPTY_WORD, 0, 0, 0, 1, STS_FILLED, 1, 0, 0, 0));
		// walk to the marker module and close a channel there
		dir_rows.push_back(mk_row(ACT_PARSE, 1, EMPTY_WORD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		repeat (6) dir_rows.push_back(mk_row(ACT_PARSE, 0, EMPTY_WORD, 0, 0, 0, 0,
			0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, EMPTY_WORD, 0, 0, 0, 1, STS_MARKER, 0, 8, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, 16'h0001, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, MARKER_WORD, 0, 0, 0, 1, STS_MARKER, 0, 8, 0, 0));
		dir_rows.push_back(mk_row(ACT_PARSE, 0, MARKER_WORD, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		for (p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				case (p)
					1: apply_settings(12'd0, 13'd4096, 4'd0);
					2: apply_settings(12'd4095, 13'd1, 4'd12);
					3: apply_settings(12'd100, 13'd3000, 4'd5);
					4: apply_settings(12'd2048, 13'd2048, 4'd3);
					default: apply_settings(12'd7, 13'd4000, 4'd1);
				endcase
			end
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 47; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 47; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			phase_start = words_sent;
			while (words_sent - phase_start < WORDS_PER_PHASE) begin
				if (p == 3 && !hold_asked && words_sent - phase_start >= 20) begin
					hold_requests++;
					hold_asked = 1'b1;
				end
				if (p == 4 && !paused && words_sent - phase_start >= 30) begin
					drain_results();
					paused = 1'b1;
				end
				send_event();
			end
		end

		drain_results();
		$display("sent %0d words over %0d register settings: %0d results checked", words_sent,
			PHASES, results_checked);
		$display("%0d samples filled, %0d dropped, %0d count reads and clears", fills_seen,
			drops_seen, selects_seen);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("** detector_word_histogrammer_core: PASSED **");
		end else begin
			$display("** detector_word_histogrammer_core: FAILED **");
		end
		$finish;
	end

endmodule
